/* rtl/core/bfm_pkg.sv */
// package with shared types, command and status codes for the buffer frame manager
`default_nettype none
package bfm_pkg;
	typedef enum logic [2:0] {
		CMD_FETCH = 3'd0,
		CMD_UNPIN = 3'd1,
		CMD_NEW   = 3'd2,
		CMD_FLUSH = 3'd3,
		CMD_FLALL = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FRAME = 2'd1,
		ST_NOT_RES  = 2'd2,
		ST_NOT_PIN  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_EXEC,
		S_SCAN,
		S_OUT
	} state_t;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FRAME_W  = 4;
	localparam int unsigned WB_W     = 31;
	localparam int unsigned PIN_W    = 8;
	localparam int unsigned MAX_RES  = 16;

	typedef struct packed {
		logic latch;
		logic lookup;
		logic exec;
		logic scan_start;
		logic scan_step;
	} ctl_t;

	typedef struct packed {
		logic is_flall;
		logic scan_done;
		logic scan_emit;
		logic bad_cmd;
	} sts_t;
endpackage
`default_nettype wire

/* rtl/core/bfm_if.sv */
// valid/ready channel interface carrying one payload struct
`default_nettype none
interface bfm_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/bfm_ctrl.sv */
// controller state machine sequencing lookup, execute and flush-all scan
`default_nettype none
module bfm_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              res_valid,
	input  wire logic         res_ready,
	input  wire logic         res_last,
	input  wire bfm_pkg::sts_t sts,
	output bfm_pkg::ctl_t     ctl
);
	bfm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			bfm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = bfm_pkg::S_LOOKUP;
				end
			end
			bfm_pkg::S_LOOKUP: begin
				ctl.lookup = 1'b1;
				priority if (sts.bad_cmd) begin
					state_d = bfm_pkg::S_IDLE;
				end else if (sts.is_flall) begin
					ctl.scan_start = 1'b1;
					state_d        = bfm_pkg::S_SCAN;
				end else begin
					state_d = bfm_pkg::S_EXEC;
				end
			end
			bfm_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = bfm_pkg::S_OUT;
			end
			bfm_pkg::S_SCAN: begin
				ctl.scan_step = 1'b1;
				if (sts.scan_emit || sts.scan_done) state_d = bfm_pkg::S_OUT;
			end
			bfm_pkg::S_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					if (res_last) begin
						state_d = bfm_pkg::S_IDLE;
					end else begin
						state_d = bfm_pkg::S_SCAN;
					end
				end
			end
			default: state_d = bfm_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/core/bfm_dpath.sv */
// frame table, lru list and result register
`default_nettype none
module bfm_dpath #(
	parameter int unsigned FRAMES       = 16,
	parameter int unsigned PAGE_ID_BITS = 31
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bfm_pkg::ctl_t              ctl,
	output bfm_pkg::sts_t                   sts,
	input  wire logic [bfm_pkg::CMD_W-1:0]  in_cmd,
	input  wire logic [PAGE_ID_BITS-1:0]    in_page_id,
	input  wire logic                       in_mark_dirty,
	output logic [bfm_pkg::STATUS_W-1:0]    o_status,
	output logic [bfm_pkg::FRAME_W-1:0]     o_frame,
	output logic                            o_load_needed,
	output logic                            o_writeback_valid,
	output logic [bfm_pkg::WB_W-1:0]        o_writeback_page,
	output logic                            o_last
);
	localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned CW = $clog2(FRAMES + 1);
	localparam int unsigned NW = $clog2(bfm_pkg::MAX_RES + 1);
	localparam logic [bfm_pkg::PIN_W-1:0] PIN_MAX = '1;

	logic [PAGE_ID_BITS-1:0]   page_q [FRAMES];
	logic [FRAMES-1:0]         valid_q, dirty_q;
	logic [bfm_pkg::PIN_W-1:0] pin_q [FRAMES];
	logic [FW-1:0]             lru_q [FRAMES];
	logic [CW-1:0]             lru_cnt_q, unused_q;

	logic [bfm_pkg::CMD_W-1:0] cmd_q;
	logic [PAGE_ID_BITS-1:0]   pid_q;
	logic                      md_q;
	logic                      hit_q;
	logic [FW-1:0]             hf_q;
	logic [FW-1:0]             scan_q;
	logic                      scan_end_q;
	logic [NW-1:0]             n_q;

	logic [bfm_pkg::STATUS_W-1:0] st_q;
	logic [FW-1:0]                fr_q;
	logic                         ld_q, wv_q, last_q;
	logic [PAGE_ID_BITS-1:0]      wp_q;

	// lookup: lowest valid match
	logic          hit_c;
	logic [FW-1:0] hf_c;
	always_comb begin
		hit_c = 1'b0;
		hf_c  = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (valid_q[i] && page_q[i] == pid_q) begin
				hit_c = 1'b1;
				hf_c  = FW'(i);
			end
		end
	end

	// remove frame rem_f from lru list: position and presence
	logic [FW-1:0] rem_f;
	logic [FRAMES-1:0] rem_match;
	logic [FRAMES-1:0] rem_after;
	logic              rem_hit;
	always_comb begin
		rem_match = '0;
		for (int i = 0; i < FRAMES; i++)
			rem_match[i] = (CW'(i) < lru_cnt_q) && (lru_q[i] == rem_f);
		rem_after = '0;
		rem_hit   = 1'b0;
		for (int i = 0; i < FRAMES; i++) begin
			rem_hit      = rem_hit | rem_match[i];
			rem_after[i] = rem_hit;
		end
	end

	wire is_fetch = cmd_q == bfm_pkg::CMD_FETCH;
	wire is_unpin = cmd_q == bfm_pkg::CMD_UNPIN;
	wire is_new   = cmd_q == bfm_pkg::CMD_NEW;
	wire is_flush = cmd_q == bfm_pkg::CMD_FLUSH;
	wire is_flall = cmd_q == bfm_pkg::CMD_FLALL;
	wire install  = is_new || (is_fetch && !hit_q);
	wire use_unused = unused_q < CW'(FRAMES);
	wire [FW-1:0] victim = use_unused ? unused_q[FW-1:0] : lru_q[0];
	wire have_victim = use_unused || (lru_cnt_q != '0);
	wire victim_dirty = valid_q[victim] && dirty_q[victim];
	wire [bfm_pkg::PIN_W-1:0] pin_h = pin_q[hf_q];
	wire unpin_ok = hit_q && pin_h != '0;
	wire push = is_unpin && unpin_ok && pin_h == bfm_pkg::PIN_W'(1);
	wire do_remove = (is_fetch && hit_q) || push ||
		(install && have_victim && !use_unused);

	assign rem_f = (install) ? victim : hf_q;
	wire scan_hit = valid_q[scan_q] && dirty_q[scan_q];

	assign sts.is_flall  = is_flall;
	assign sts.bad_cmd   = !(is_fetch || is_unpin || is_new || is_flush || is_flall);
	assign sts.scan_emit = ctl.scan_step && !scan_end_q && scan_hit &&
		n_q < NW'(bfm_pkg::MAX_RES);
	assign sts.scan_done = ctl.scan_step &&
		(scan_end_q || n_q >= NW'(bfm_pkg::MAX_RES));

	// next lru list: remove, then append at the back
	logic [FW-1:0] lru_d [FRAMES];
	logic [CW-1:0] lru_cnt_d;
	always_comb begin
		lru_d     = lru_q;
		lru_cnt_d = lru_cnt_q;
		if (do_remove) begin
			for (int i = 0; i < FRAMES - 1; i++)
				if (rem_after[i]) lru_d[i] = lru_q[i + 1];
			if (rem_hit) lru_cnt_d = lru_cnt_q - CW'(1);
		end
		if (push && lru_cnt_d < CW'(FRAMES)) begin
			lru_d[lru_cnt_d[FW-1:0]] = hf_q;
			lru_cnt_d                = lru_cnt_d + CW'(1);
		end
	end

	// next result
	logic [bfm_pkg::STATUS_W-1:0] st_d;
	logic [FW-1:0]                fr_d;
	logic                         ld_d, wv_d, last_d;
	logic [PAGE_ID_BITS-1:0]      wp_d;
	always_comb begin
		st_d   = bfm_pkg::ST_OK;
		fr_d   = '0;
		ld_d   = 1'b0;
		wv_d   = 1'b0;
		wp_d   = '0;
		last_d = 1'b1;
		priority if (sts.scan_emit) begin
			fr_d   = scan_q;
			wv_d   = 1'b1;
			wp_d   = page_q[scan_q];
			last_d = 1'b0;
		end else if (sts.scan_done) begin
			if (n_q != '0) begin
				st_d = st_q;
				fr_d = fr_q;
				ld_d = ld_q;
				wv_d = wv_q;
				wp_d = wp_q;
			end
		end else if (install) begin
			if (have_victim) begin
				fr_d = victim;
				ld_d = is_fetch;
				wv_d = victim_dirty;
				wp_d = victim_dirty ? page_q[victim] : '0;
			end else begin
				st_d = bfm_pkg::ST_NO_FRAME;
			end
		end else if (!hit_q) begin
			st_d = bfm_pkg::ST_NOT_RES;
		end else if (is_unpin && !unpin_ok) begin
			st_d = bfm_pkg::ST_NOT_PIN;
		end else begin
			fr_d = hf_q;
			if (is_flush) begin
				wv_d = 1'b1;
				wp_d = page_q[hf_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= in_cmd;
			pid_q <= in_page_id;
			md_q  <= in_mark_dirty;
		end
		if (ctl.lookup) begin
			hit_q <= hit_c;
			hf_q  <= hf_c;
		end
		if (ctl.exec && install && have_victim) page_q[victim] <= pid_q;
		if (ctl.exec || sts.scan_emit || sts.scan_done) begin
			st_q   <= st_d;
			fr_q   <= fr_d;
			ld_q   <= ld_d;
			wv_q   <= wv_d;
			wp_q   <= wp_d;
			last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			dirty_q    <= '0;
			lru_cnt_q  <= '0;
			unused_q   <= '0;
			scan_q     <= '0;
			scan_end_q <= 1'b0;
			n_q        <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				pin_q[i] <= '0;
				lru_q[i] <= '0;
			end
		end else begin
			if (ctl.exec) begin
				if (install && have_victim) begin
					valid_q[victim] <= 1'b1;
					dirty_q[victim] <= 1'b0;
					pin_q[victim]   <= bfm_pkg::PIN_W'(1);
					if (use_unused) unused_q <= unused_q + CW'(1);
				end else if (hit_q) begin
					if (is_fetch && pin_h != PIN_MAX)
						pin_q[hf_q] <= pin_h + bfm_pkg::PIN_W'(1);
					if (is_unpin && md_q) dirty_q[hf_q] <= 1'b1;
					if (is_unpin && unpin_ok) pin_q[hf_q] <= pin_h - bfm_pkg::PIN_W'(1);
					if (is_flush) dirty_q[hf_q] <= 1'b0;
				end
				lru_q     <= lru_d;
				lru_cnt_q <= lru_cnt_d;
			end
			if (ctl.scan_start) begin
				scan_q     <= '0;
				scan_end_q <= 1'b0;
				n_q        <= '0;
			end
			if (ctl.scan_step && !sts.scan_done) begin
				if (sts.scan_emit) begin
					dirty_q[scan_q] <= 1'b0;
					n_q             <= n_q + NW'(1);
				end
				if (scan_q == FW'(FRAMES - 1)) scan_end_q <= 1'b1;
				else scan_q <= scan_q + FW'(1);
			end
		end
	end

	// whether any further dirty valid frame exists past the one being output; also set once MAX_RES results were emitted
	logic lookahead_none;
	always_comb begin
		lookahead_none = 1'b1;
		for (int i = 0; i < FRAMES; i++)
			if (CW'(i) > CW'(fr_q) && valid_q[i] && dirty_q[i]) lookahead_none = 1'b0;
		if (n_q >= NW'(bfm_pkg::MAX_RES)) lookahead_none = 1'b1;
	end

	// flush-all: each found frame is output while scanning ahead for the last flag
	assign o_status          = st_q;
	assign o_frame           = bfm_pkg::FRAME_W'(fr_q);
	assign o_load_needed     = ld_q;
	assign o_writeback_valid = wv_q;
	assign o_writeback_page  = bfm_pkg::WB_W'(wp_q);
	assign o_last            = last_q | (is_flall && lookahead_none);
endmodule
`default_nettype wire

/* rtl/core/buffer_frame_manager_unit.sv */
// top level of the buffer frame manager
// each item: latch, table search, execute, result transfer; the next request waits until the result is taken
// flush all: frames are scanned in order, a result per dirty frame (up to MAX_RES), one result if none is dirty
// unknown commands give no result and go back to idle after lookup; a held result waits for rsp.ready
// arst_n clears all valid, pin and dirty marks, the lru count and the unused pointer
`default_nettype none
module buffer_frame_manager_unit #(
	parameter int unsigned FRAMES       = 16,
	parameter int unsigned PAGE_ID_BITS = 31
) (
	input wire logic clk,
	input wire logic arst_n,
	bfm_if.sink      req,
	bfm_if.source    rsp
);
	bfm_pkg::ctl_t ctl;
	bfm_pkg::sts_t sts;
	logic res_valid;

	bfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.res_valid (res_valid),
		.res_ready (rsp.ready),
		.res_last  (rsp.data.last),
		.sts       (sts),
		.ctl       (ctl)
	);

	bfm_dpath #(.FRAMES(FRAMES), .PAGE_ID_BITS(PAGE_ID_BITS)) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.sts               (sts),
		.in_cmd            (req.data.cmd),
		.in_page_id        (PAGE_ID_BITS'(req.data.page_id)),
		.in_mark_dirty     (req.data.mark_dirty),
		.o_status          (rsp.data.status),
		.o_frame           (rsp.data.frame),
		.o_load_needed     (rsp.data.load_needed),
		.o_writeback_valid (rsp.data.writeback_valid),
		.o_writeback_page  (rsp.data.writeback_page),
		.o_last            (rsp.data.last)
	);

	assign rsp.valid = res_valid;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("input taken while result pending");
	a_ok_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status != bfm_pkg::ST_OK |-> rsp.data.frame == '0)
		else $error("frame nonzero on error");
	a_load_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.load_needed |-> rsp.data.status == bfm_pkg::ST_OK)
		else $error("load with error status");
endmodule
`default_nettype wire
